// File: rtl/vn_pkg.sv
package vn_pkg;

    // default field widths
    localparam int COMPONENT_WIDTH_DEF    = 16;
    localparam int UNIT_FRACTION_BITS_DEF = 14;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: rtl/vn_if.sv
// input channel: one vector
interface vn_in_if #(
    parameter int COMPONENT_WIDTH = vn_pkg::COMPONENT_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [COMPONENT_WIDTH-1:0] x_comp;
    logic signed [COMPONENT_WIDTH-1:0] y_comp;
    logic signed [COMPONENT_WIDTH-1:0] z_comp;

    modport source (output valid, x_comp, y_comp, z_comp, input ready);
    modport sink   (input valid, x_comp, y_comp, z_comp, output ready);
endinterface

// output channel: magnitude and unit vector
interface vn_out_if #(
    parameter int COMPONENT_WIDTH    = vn_pkg::COMPONENT_WIDTH_DEF,
    parameter int UNIT_FRACTION_BITS = vn_pkg::UNIT_FRACTION_BITS_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic        [COMPONENT_WIDTH-1:0]    magnitude;
    logic signed [UNIT_FRACTION_BITS+1:0] unit_x;
    logic signed [UNIT_FRACTION_BITS+1:0] unit_y;
    logic signed [UNIT_FRACTION_BITS+1:0] unit_z;
    logic                                 zero_length;

    modport source (output valid, magnitude, unit_x, unit_y, unit_z, zero_length,
                    input ready);
    modport sink   (input valid, magnitude, unit_x, unit_y, unit_z, zero_length,
                    output ready);
endinterface

// File: rtl/vn_fifo.sv
module vn_fifo #(
    parameter int WIDTH = 67,
    parameter int DEPTH = vn_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output vn_pkg::t_q_stat  o_stat
);
    import vn_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    // only legal moves take effect
    assign w_push = i_push && (r_count != CW'(DEPTH));
    assign w_pop  = i_pop && (r_count != '0);

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");
    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

// File: rtl/vn_front.sv
module vn_front #(
    parameter int COMPONENT_WIDTH = vn_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    vn_in_if.sink                      i_in,
    input  vn_pkg::t_q_stat            i_q_stat,
    output logic                       o_push,
    output logic [COMPONENT_WIDTH-1:0] o_mag,
    output logic [COMPONENT_WIDTH-1:0] o_ax,
    output logic [COMPONENT_WIDTH-1:0] o_ay,
    output logic [COMPONENT_WIDTH-1:0] o_az,
    output logic [2:0]                 o_neg
);
    import vn_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    // abs stage, sum stage, one stage per root bit
    localparam int NS   = CW + 2;
    localparam int LAST = NS - 1;

    logic            r_v    [NS];
    logic [CW-1:0]   r_ax   [NS];
    logic [CW-1:0]   r_ay   [NS];
    logic [CW-1:0]   r_az   [NS];
    logic [2:0]      r_neg  [NS];
    logic [2*CW-1:0] r_s    [NS];
    logic [CW+1:0]   r_rem  [NS];
    logic [CW-1:0]   r_root [NS];
    logic            w_adv;

    // whole pipe moves unless the last stage is blocked by a full queue
    assign w_adv      = !r_v[LAST] || !i_q_stat.full;
    assign i_in.ready = w_adv;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v[0] <= i_in.valid;
            for (int k = 1; k < NS; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 0: sign and absolute value
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_neg[0] <= {i_in.z_comp[CW-1], i_in.y_comp[CW-1], i_in.x_comp[CW-1]};
            r_ax[0]  <= i_in.x_comp[CW-1] ? CW'(-i_in.x_comp) : CW'(i_in.x_comp);
            r_ay[0]  <= i_in.y_comp[CW-1] ? CW'(-i_in.y_comp) : CW'(i_in.y_comp);
            r_az[0]  <= i_in.z_comp[CW-1] ? CW'(-i_in.z_comp) : CW'(i_in.z_comp);
            r_s[0]   <= '0;
            r_rem[0] <= '0;
            r_root[0] <= '0;
        end
    end

    // stage 1: sum of squares, full width
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_neg[1]  <= r_neg[0];
            r_ax[1]   <= r_ax[0];
            r_ay[1]   <= r_ay[0];
            r_az[1]   <= r_az[0];
            r_s[1]    <= (2*CW)'(r_ax[0]) * (2*CW)'(r_ax[0])
                       + (2*CW)'(r_ay[0]) * (2*CW)'(r_ay[0])
                       + (2*CW)'(r_az[0]) * (2*CW)'(r_az[0]);
            r_rem[1]  <= '0;
            r_root[1] <= '0;
        end
    end

    // one root bit per stage, two sum bits shifted in each time
    for (genvar j = 0; j < CW; j++) begin : g_sqrt
        logic [CW+3:0] w_cand;
        logic [CW+3:0] w_trial;
        logic          w_ge;

        assign w_cand  = {r_rem[j+1], r_s[j+1][2*(CW-1-j) +: 2]};
        assign w_trial = {2'b00, r_root[j+1], 2'b01};
        assign w_ge    = (w_cand >= w_trial);

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_neg[j+2] <= r_neg[j+1];
                r_ax[j+2]  <= r_ax[j+1];
                r_ay[j+2]  <= r_ay[j+1];
                r_az[j+2]  <= r_az[j+1];
                r_s[j+2]   <= r_s[j+1];
                if (w_ge) begin
                    r_rem[j+2]  <= (CW+2)'(w_cand - w_trial);
                    r_root[j+2] <= {r_root[j+1][CW-2:0], 1'b1};
                end else begin
                    r_rem[j+2]  <= (CW+2)'(w_cand);
                    r_root[j+2] <= {r_root[j+1][CW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_push = r_v[LAST] && !i_q_stat.full;
    assign o_mag  = r_root[LAST];
    assign o_ax   = r_ax[LAST];
    assign o_ay   = r_ay[LAST];
    assign o_az   = r_az[LAST];
    assign o_neg  = r_neg[LAST];

endmodule

// File: rtl/vn_back.sv
module vn_back #(
    parameter int COMPONENT_WIDTH    = vn_pkg::COMPONENT_WIDTH_DEF,
    parameter int UNIT_FRACTION_BITS = vn_pkg::UNIT_FRACTION_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  vn_pkg::t_q_stat            i_q_stat,
    input  logic [COMPONENT_WIDTH-1:0] i_mag,
    input  logic [COMPONENT_WIDTH-1:0] i_ax,
    input  logic [COMPONENT_WIDTH-1:0] i_ay,
    input  logic [COMPONENT_WIDTH-1:0] i_az,
    input  logic [2:0]                 i_neg,
    output logic                       o_pop,
    vn_out_if.source                   o_out
);
    import vn_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int UF = UNIT_FRACTION_BITS;
    localparam int QW = UF + 1;
    // one stage per quotient bit
    localparam int NS   = QW;
    localparam int LAST = NS - 1;

    logic          r_v    [NS];
    logic [CW-1:0] r_mag  [NS];
    logic [2:0]    r_neg  [NS];
    logic [CW-1:0] r_rem  [NS][3];
    logic [QW-1:0] r_q    [NS][3];
    logic          r_o_v;
    logic          w_adv;
    logic [CW-1:0] w_a    [3];

    assign w_a[0] = i_ax;
    assign w_a[1] = i_ay;
    assign w_a[2] = i_az;

    // pipe moves unless the output register is held
    assign w_adv = !r_o_v || o_out.ready;
    assign o_pop = w_adv && !i_q_stat.empty;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_v[k] <= 1'b0;
            end
            r_o_v <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= !i_q_stat.empty;
            for (int k = 1; k < NS; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_o_v <= r_v[LAST];
        end
    end

    // restoring division, three lanes; quotient never exceeds 2^UF
    for (genvar k = 0; k < NS; k++) begin : g_div
        logic [CW-1:0] w_dv;
        logic [2:0]    w_nin;

        // divisor and signs come from the queue or the previous stage
        if (k == 0) begin : g_head
            assign w_dv  = i_mag;
            assign w_nin = i_neg;
        end else begin : g_tail
            assign w_dv  = r_mag[k-1];
            assign w_nin = r_neg[k-1];
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [CW:0]   w_cand;
            logic [CW-1:0] w_rin;
            logic [QW-1:0] w_qin;
            logic          w_ge;

            if (k == 0) begin : g_first
                assign w_rin  = {1'b0, w_a[l][CW-1:1]};
                assign w_qin  = '0;
                assign w_cand = {w_rin, w_a[l][0]};
            end else begin : g_rest
                assign w_rin  = r_rem[k-1][l];
                assign w_qin  = r_q[k-1][l];
                assign w_cand = {w_rin, 1'b0};
            end
            assign w_ge = (w_cand >= {1'b0, w_dv});

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    if (w_ge) begin
                        r_rem[k][l] <= CW'(w_cand - {1'b0, w_dv});
                    end else begin
                        r_rem[k][l] <= CW'(w_cand);
                    end
                    r_q[k][l] <= {w_qin[QW-2:0], w_ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_mag[k] <= w_dv;
                r_neg[k] <= w_nin;
            end
        end
    end

    // output register: sign, zero-length forcing
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_out.magnitude   <= r_mag[LAST];
            o_out.zero_length <= (r_mag[LAST] == '0);
            if (r_mag[LAST] == '0) begin
                o_out.unit_x <= '0;
                o_out.unit_y <= '0;
                o_out.unit_z <= '0;
            end else begin
                o_out.unit_x <= r_neg[LAST][0] ? -(UF+2)'(r_q[LAST][0])
                                               : (UF+2)'(r_q[LAST][0]);
                o_out.unit_y <= r_neg[LAST][1] ? -(UF+2)'(r_q[LAST][1])
                                               : (UF+2)'(r_q[LAST][1]);
                o_out.unit_z <= r_neg[LAST][2] ? -(UF+2)'(r_q[LAST][2])
                                               : (UF+2)'(r_q[LAST][2]);
            end
        end
    end

    assign o_out.valid = r_o_v;

`ifndef NO_ASSERTIONS
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> (o_out.zero_length == (o_out.magnitude == '0)))
        else $error("zero flag disagrees with magnitude");
    a_zero_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && o_out.zero_length) |->
        (o_out.unit_x == '0 && o_out.unit_y == '0 && o_out.unit_z == '0))
        else $error("zero vector gave nonzero unit");
    a_no_pop_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && !o_out.ready) |-> !o_pop)
        else $error("queue popped while output stalled");
`endif

endmodule

// File: rtl/vector3_normalize.sv
// vector3_normalize: takes one signed 3D vector (12 fraction bits) per item and returns
// the magnitude floor(sqrt(x*x+y*y+z*z)) and each component times 2^UNIT_FRACTION_BITS
// divided by the magnitude, truncated toward zero; a zero vector gives zero units with
// zero_length set. One vector is accepted every cycle while the output is taken. An item
// enters the first of COMPONENT_WIDTH+2 front stages at its accepting edge (abs, sum of
// squares, one square root stage per magnitude bit), is written to the queue after the
// last of them, enters the first of UNIT_FRACTION_BITS+1 divider stages (one per quotient
// bit) as it is popped, and then the output register. A small queue between the square
// root and the dividers lets each side stall on its own.
module vector3_normalize #(
    parameter int COMPONENT_WIDTH    = vn_pkg::COMPONENT_WIDTH_DEF,
    parameter int UNIT_FRACTION_BITS = vn_pkg::UNIT_FRACTION_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    vn_in_if.sink    i_in,
    vn_out_if.source o_out
);
    import vn_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int QDW = 4 * CW + 3;

    t_q_stat          w_q_stat;
    logic             w_push;
    logic             w_pop;
    logic [CW-1:0]    w_f_mag, w_f_ax, w_f_ay, w_f_az;
    logic [2:0]       w_f_neg;
    logic [CW-1:0]    w_b_mag, w_b_ax, w_b_ay, w_b_az;
    logic [2:0]       w_b_neg;
    logic [QDW-1:0]   w_q_wdata;
    logic [QDW-1:0]   w_q_rdata;

    // square root side
    vn_front #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_mag    (w_f_mag),
        .o_ax     (w_f_ax),
        .o_ay     (w_f_ay),
        .o_az     (w_f_az),
        .o_neg    (w_f_neg)
    );

    // queue between root and dividers
    assign w_q_wdata = {w_f_neg, w_f_az, w_f_ay, w_f_ax, w_f_mag};
    assign {w_b_neg, w_b_az, w_b_ay, w_b_ax, w_b_mag} = w_q_rdata;

    vn_fifo #(
        .WIDTH (QDW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_pop),
        .o_data  (w_q_rdata),
        .o_stat  (w_q_stat)
    );

    // divider side
    vn_back #(
        .COMPONENT_WIDTH    (COMPONENT_WIDTH),
        .UNIT_FRACTION_BITS (UNIT_FRACTION_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_mag    (w_b_mag),
        .i_ax     (w_b_ax),
        .i_ay     (w_b_ay),
        .i_az     (w_b_az),
        .i_neg    (w_b_neg),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

endmodule
